FILE: hdl/aip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_pkg
// Shared beat types, character codes and base codes for the ASCII integer
// parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    // Width of the base configuration register.
    localparam int unsigned BASE_BITS = 6;

    // Values of the base register that the parser understands.
    localparam logic [BASE_BITS-1:0] CFG_BASE_AUTO = 6'd0;
    localparam logic [BASE_BITS-1:0] CFG_BASE_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] CFG_BASE_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] CFG_BASE_HEX  = 6'd16;

    // Character codes.
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_7     = 8'h37;  // '7'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_F  = 8'h46;  // 'F'
    localparam logic [7:0] CH_UP_X  = 8'h58;  // 'X'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_LO_X  = 8'h78;  // 'x'

    // One input beat: a character and the start-of-string flag.
    typedef struct packed {
        logic [7:0] char_code;
        logic       starts_string;
    } t_in_item;

    // One result beat: the converted value and where parsing stopped.
    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic [15:0]        end_offset;
    } t_out_item;

endpackage : aip_pkg
`default_nettype wire

FILE: hdl/aip_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_core
// Conversion state and result register. Each step takes one character,
// updates the accumulator with a shift-and-add when it is a digit of the
// chosen base, and emits a result beat at the first non-digit past the prefix.
// ----------------------------------------------------------------------------
module aip_core
    import aip_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire t_in_item             i_item,
    input  wire logic [BASE_BITS-1:0] i_number_base,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output t_out_item                 o_res_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        AB_NONE,
        AB_OCT,
        AB_DEC,
        AB_HEX
    } t_base;

    // Digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] digit_of(input logic [7:0] c, input t_base b);
        logic [4:0] r;
        r = 5'd0;
        case (b)
            AB_HEX: begin
                if (c inside {[CH_0:CH_9]}) begin
                    r = {1'b1, 4'(c - CH_0)};
                end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
                    r = {1'b1, 4'(c - CH_LO_A + 8'd10)};
                end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
                    r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
                end
            end
            AB_DEC: begin
                if (c inside {[CH_0:CH_9]}) begin
                    r = {1'b1, 4'(c - CH_0)};
                end
            end
            AB_OCT: begin
                if (c inside {[CH_0:CH_7]}) begin
                    r = {1'b1, 4'(c - CH_0)};
                end
            end
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    t_phase                r_phase, n_phase;
    t_base                 r_base, n_base;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_res_valid;
    t_out_item             r_res_data;

    logic                  w_emit;
    t_base                 w_take_base;
    logic [VALUE_BITS-1:0] w_acc_in;
    logic [COUNT_BITS-1:0] w_cnt_in;
    logic                  w_take;
    logic [4:0]            w_digit;
    logic [VALUE_BITS-1:0] w_scaled;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [31:0]           w_cnt_wide;
    t_base                 w_cfg_base;

    // Map the base register to a base code.
    always_comb begin
        case (i_number_base)
            CFG_BASE_OCT: w_cfg_base = AB_OCT;
            CFG_BASE_DEC: w_cfg_base = AB_DEC;
            CFG_BASE_HEX: w_cfg_base = AB_HEX;
            default:      w_cfg_base = AB_NONE;
        endcase
    end

    // Pick the base, accumulator and count that the digit step works from.
    always_comb begin
        n_phase     = r_phase;
        n_base      = r_base;
        w_take      = 1'b0;
        w_take_base = r_base;
        w_acc_in    = r_acc;
        w_cnt_in    = r_count;
        if (i_step) begin
            if (i_item.starts_string) begin
                w_acc_in = '0;
                w_cnt_in = '0;
                n_phase  = PH_DIGITS;
                if (i_number_base == CFG_BASE_AUTO) begin
                    if (i_item.char_code == CH_0) begin
                        n_base  = AB_OCT;
                        n_phase = PH_PREFIX;
                    end else begin
                        n_base = AB_DEC;
                        w_take = 1'b1;
                    end
                end else begin
                    n_base = w_cfg_base;
                    w_take = 1'b1;
                end
                w_take_base = n_base;
            end else if (r_phase == PH_PREFIX) begin
                n_phase = PH_DIGITS;
                if (i_item.char_code == CH_LO_X || i_item.char_code == CH_UP_X) begin
                    n_base = AB_HEX;
                end else begin
                    n_base = AB_OCT;
                    w_take = 1'b1;
                end
                w_take_base = n_base;
            end else if (r_phase == PH_DIGITS) begin
                w_take = 1'b1;
            end
        end
    end

    // Digit step: value times base plus digit, or finish on a non-digit.
    always_comb begin
        w_digit   = digit_of(i_item.char_code, w_take_base);
        w_cnt_inc = (w_cnt_in == '1) ? w_cnt_in : w_cnt_in + 1'b1;
        case (w_take_base)
            AB_HEX:  w_scaled = w_acc_in << 4;
            AB_DEC:  w_scaled = (w_acc_in << 3) + (w_acc_in << 1);
            default: w_scaled = w_acc_in << 3;
        endcase
        n_acc   = w_acc_in;
        n_count = w_cnt_in;
        w_emit  = 1'b0;
        if (i_step) begin
            if (w_take) begin
                if (w_digit[4]) begin
                    n_acc   = w_scaled + VALUE_BITS'(w_digit[3:0]);
                    n_count = w_cnt_inc;
                end else begin
                    w_emit = 1'b1;
                end
            end else if (i_item.starts_string || r_phase == PH_PREFIX) begin
                // Prefix character consumed without a digit.
                n_count = w_cnt_inc;
            end
        end
        w_cnt_wide = 32'(w_cnt_in);
    end

    // Conversion state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_base      <= AB_NONE;
            r_acc       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_count <= n_count;
            if (w_emit) begin
                r_phase     <= PH_IDLE;
                r_res_valid <= 1'b1;
            end else begin
                r_phase <= n_phase;
                if (i_res_ready) begin
                    r_res_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res_data.parsed_value <= 64'(signed'(w_acc_in));
            r_res_data.end_offset   <= w_cnt_wide[15:0];
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res_data;

endmodule : aip_core
`default_nettype wire

FILE: hdl/ascii_integer_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Converts a stream of ASCII characters into an unsigned integer in base 8,
// 10 or 16, with automatic base detection from a "0x" or "0" prefix.
// ----------------------------------------------------------------------------
// The parser takes one character beat per clock cycle while its input is not
// stalled. An accepted beat is held in the input register, and the conversion
// step (a shift-and-add on the accumulator) runs as the beat leaves it. When
// that beat is the first character that is not a digit, the step loads the
// result register, from which the result is shown. The accumulator
// loop closes within the step, which sets the rate of an unstalled input
// at one character per cycle. The base register is sampled when a
// start-of-string beat leaves the input register. The input stalls only while
// a result waits in the result register and is not being taken.
module ascii_integer_parser
    import aip_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [BASE_BITS-1:0] i_cfg_data
);

    logic                 r_in_valid;
    t_in_item             r_in_item;
    logic [BASE_BITS-1:0] r_number_base;
    logic                 w_step;
    logic                 w_res_valid;

    // A held beat moves on when the result register can take a result.
    assign w_step     = r_in_valid && (!w_res_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // Base configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= CFG_BASE_AUTO;
        end else if (i_cfg_valid) begin
            r_number_base <= i_cfg_data;
        end
    end

    // Conversion step and result register.
    aip_core #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_item        (r_in_item),
        .i_number_base (r_number_base),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (i_out_ready),
        .o_res_data    (o_out_data)
    );

    assign o_out_valid = w_res_valid;

endmodule : ascii_integer_parser
`default_nettype wire

FILE: tb/tb_ascii_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser
// Self-checking testbench for the ASCII integer parser. Character beats are
// driven through the input handshake, and a predictor in the testbench works
// out each conversion result. Every result beat is checked field by field
// against the oldest pending prediction. Directed strings cover the base
// prefixes, the fixed bases, restarts and value wrap. A long random part
// then runs with and without stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;
    import aip_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_REPORTS     = 100;

    // A base value that the parser does not support; it selects no digits.
    localparam logic [BASE_BITS-1:0] BASE_UNSUPPORTED_MAX = 6'd36;

    // Scan state and radix of the conversion in progress.
    typedef enum logic [1:0] {SCAN_IDLE, SCAN_LEAD_ZERO, SCAN_DIGITS} t_scan;
    typedef enum logic [1:0] {RADIX_NONE, RADIX_OCT, RADIX_DEC, RADIX_HEX} t_radix;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [BASE_BITS-1:0] i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 o_cfg_ready;

    // Predictor state, mirrors the parser after reset.
    logic [BASE_BITS-1:0] base_setting = CFG_BASE_AUTO;
    t_scan                scan_state   = SCAN_IDLE;
    t_radix               radix        = RADIX_NONE;
    logic [63:0]          acc_value    = '0;
    logic [15:0]          chars_used   = '0;

    // Predicted conversions not yet seen on the result port.
    t_out_item            parses_due[$];

    // Stimulus control and run statistics.
    logic [BASE_BITS-1:0] gen_base      = CFG_BASE_AUTO;
    int                   tx_idle_pct   = 0;
    int                   rx_idle_pct   = 0;
    bit                   hold_request  = 1'b0;
    int                   hold_left     = 0;
    bit                   line_open     = 1'b0;
    int                   random_chars  = 0;
    int                   beats_in      = 0;
    int                   results_seen  = 0;
    int                   fail_count    = 0;
    int                   cycle_count   = 0;

    ascii_integer_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_radix radix_of(input logic [BASE_BITS-1:0] b);
        case (b)
            CFG_BASE_OCT: return RADIX_OCT;
            CFG_BASE_DEC: return RADIX_DEC;
            CFG_BASE_HEX: return RADIX_HEX;
            default:      return RADIX_NONE;
        endcase
    endfunction

    // Digit weight of a character in a radix, or -1 when it is not a digit.
    function automatic int digit_value(input logic [7:0] c, input t_radix r);
        if (r == RADIX_HEX) begin
            if (c >= CH_LO_A && c <= CH_LO_F) return c - CH_LO_A + 10;
            if (c >= CH_UP_A && c <= CH_UP_F) return c - CH_UP_A + 10;
            if (c >= CH_0 && c <= CH_9) return c - CH_0;
        end else if (r == RADIX_DEC) begin
            if (c >= CH_0 && c <= CH_9) return c - CH_0;
        end else if (r == RADIX_OCT) begin
            if (c >= CH_0 && c <= CH_7) return c - CH_0;
        end
        return -1;
    endfunction

    // The consumed-character count holds at its maximum.
    function automatic void count_up();
        if (chars_used != 16'hFFFF) chars_used = chars_used + 16'd1;
    endfunction

    // Accumulates a digit, or closes the conversion and returns 1 with the result.
    function automatic bit digit_or_close(input logic [7:0] c, output t_out_item res);
        int          d;
        logic [63:0] mul;
        d = digit_value(c, radix);
        res = '0;
        if (d >= 0) begin
            mul = (radix == RADIX_HEX) ? 64'd16 : (radix == RADIX_DEC) ? 64'd10 : 64'd8;
            acc_value = acc_value * mul + 64'(d);
            count_up();
            return 1'b0;
        end
        res.parsed_value = acc_value;
        res.end_offset   = chars_used;
        scan_state       = SCAN_IDLE;
        return 1'b1;
    endfunction

    // Advances the predictor by one accepted character beat.
    function automatic bit scan_char(input t_in_item beat, output t_out_item res);
        res = '0;
        if (beat.starts_string) begin
            acc_value  = '0;
            chars_used = '0;
            scan_state = SCAN_DIGITS;
            if (base_setting == CFG_BASE_AUTO) begin
                // A leading zero may open an octal number or a hex prefix.
                if (beat.char_code == CH_0) begin
                    radix      = RADIX_OCT;
                    scan_state = SCAN_LEAD_ZERO;
                    count_up();
                    return 1'b0;
                end
                radix = RADIX_DEC;
            end else begin
                radix = radix_of(base_setting);
            end
            return digit_or_close(beat.char_code, res);
        end
        if (scan_state == SCAN_LEAD_ZERO) begin
            scan_state = SCAN_DIGITS;
            if (beat.char_code == CH_LO_X || beat.char_code == CH_UP_X) begin
                radix = RADIX_HEX;
                count_up();
                return 1'b0;
            end
            radix = RADIX_OCT;
            return digit_or_close(beat.char_code, res);
        end
        if (scan_state == SCAN_DIGITS) return digit_or_close(beat.char_code, res);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: tracks accepted beats and checks every result beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : p_monitor
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) base_setting = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                beats_in++;
                if (scan_char(i_in_data, want)) parses_due.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (parses_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result beat with none pending, got value %h offset %0d",
                                 $time, o_out_data.parsed_value, o_out_data.end_offset);
                end else begin
                    want = parses_due.pop_front();
                    if (want.parsed_value !== o_out_data.parsed_value) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: parsed_value mismatch, expected %h, actual %h",
                                     $time, want.parsed_value, o_out_data.parsed_value);
                    end
                    if (want.end_offset !== o_out_data.end_offset) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: end_offset mismatch, expected %0d, actual %0d",
                                     $time, want.end_offset, o_out_data.end_offset);
                    end
                end
            end
        end
    end

    // Result side: random stalls, or a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, parses_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one character beat and waits until it is taken.
    task automatic send_char(input logic [7:0] c, input logic first);
        i_in_valid <= 1'b1;
        i_in_data  <= t_in_item'{char_code: c, starts_string: first};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Sends a string; its first character carries the start flag.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
    endtask

    // Stops offering beats and waits until every predicted result is back.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (parses_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the base register once the parser has gone quiet.
    task automatic write_base(input logic [BASE_BITS-1:0] b);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= b;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_base = b;
    endtask

    // ------------------------------------------------------------------
    // Random string generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] random_digit(input t_radix r);
        int unsigned k;
        case (r)
            RADIX_OCT: return CH_0 + 8'($urandom_range(7));
            RADIX_HEX: begin
                k = $urandom_range(21);
                if (k < 10) return CH_0 + 8'(k);
                if (k < 16) return CH_LO_A + 8'(k - 10);
                return CH_UP_A + 8'(k - 16);
            end
            default:   return CH_0 + 8'($urandom_range(9));
        endcase
    endfunction

    // Picks a non-digit, often one right next to a digit range.
    function automatic logic [7:0] random_terminator(input t_radix r, input bit no_x);
        logic [7:0] c;
        do begin
            if ($urandom_range(1)) begin
                case ($urandom_range(11))
                    0:       c = CH_0 - 8'd1;
                    1:       c = CH_9 + 8'd1;
                    2:       c = CH_7 + 8'd1;
                    3:       c = CH_9;
                    4:       c = CH_UP_A - 8'd1;
                    5:       c = CH_UP_F + 8'd1;
                    6:       c = CH_LO_A - 8'd1;
                    7:       c = CH_LO_F + 8'd1;
                    8:       c = 8'h00;
                    9:       c = 8'hFF;
                    10:      c = CH_LO_X;
                    default: c = CH_UP_X;
                endcase
            end else begin
                c = 8'($urandom_range(255));
            end
        end while (digit_value(c, r) >= 0 || (no_x && (c == CH_LO_X || c == CH_UP_X)));
        return c;
    endfunction

    // Builds a number for the current base, with or without a terminator.
    task automatic send_number(input bit terminate);
        logic [7:0] text[$];
        t_radix     r;
        int         n_digits;
        int         k;
        bit         bare_zero;
        bare_zero = 1'b0;
        n_digits  = ($urandom_range(9) == 0) ? $urandom_range(9, 25) : $urandom_range(0, 8);
        if (gen_base == CFG_BASE_AUTO) begin
            k = $urandom_range(2);
            if (k == 0) begin
                r = RADIX_HEX;
                text.push_back(CH_0);
                text.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
            end else if (k == 1) begin
                // After a bare leading zero an x would turn into a hex prefix.
                r = RADIX_OCT;
                text.push_back(CH_0);
                bare_zero = (n_digits == 0);
            end else begin
                r = RADIX_DEC;
                if (n_digits > 0) begin
                    text.push_back(CH_0 + 8'($urandom_range(1, 9)));
                    n_digits--;
                end
            end
        end else begin
            r = radix_of(gen_base);
        end
        repeat (n_digits) text.push_back(random_digit(r));
        if (terminate) text.push_back(random_terminator(r, bare_zero));
        foreach (text[i]) send_char(text[i], i == 0);
        random_chars += text.size();
        line_open = !terminate;
    endtask

    // One random unit: mostly whole numbers, some broken ones and noise.
    task automatic send_random_unit();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 72) begin
            send_number(1'b1);
        end else if (kind < 82) begin
            send_number(1'b0);
        end else if (kind < 90) begin
            // Noise without a start flag; ignored unless a number is open.
            n = $urandom_range(1, 3);
            repeat (n) send_char(8'($urandom_range(255)), 1'b0);
            if (line_open) random_chars += n;
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
            random_chars += n;
            line_open = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Base detection from the reset value of the register.
    task automatic test_auto_prefixes();
        send_text("0x1F;");
        send_text("0Xg");
        send_text("078");
        send_char(8'hFF, 1'b1);
    endtask

    // Each fixed base, then a base that accepts no digits.
    task automatic test_fixed_bases();
        write_base(CFG_BASE_HEX);
        send_text("aF/");
        write_base(CFG_BASE_OCT);
        send_text("78");
        write_base(CFG_BASE_DEC);
        send_text("9:");
        write_base(BASE_UNSUPPORTED_MAX);
        send_text("5");
    endtask

    // Ignored idle characters, restart mid-number, and a register write
    // mid-number that must only affect the next string.
    task automatic test_special_cases();
        write_base(CFG_BASE_AUTO);
        send_char(8'hFF, 1'b0);
        send_char(CH_0, 1'b1);
        send_char(CH_9, 1'b1);
        send_char(8'h00, 1'b0);
        write_base(CFG_BASE_DEC);
        send_text("12");
        write_base(CFG_BASE_HEX);
        send_char(CH_LO_A, 1'b0);
    endtask

    // Accumulator wrap in hex and decimal.
    task automatic test_value_wrap();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_base(CFG_BASE_HEX);
        send_text("ffffffffffffffffff;");
        write_base(CFG_BASE_DEC);
        send_text("99999999999999999999999 ");
        wait_quiet();
    endtask

    // Result side held off while short numbers keep coming, so the parser
    // fills up and stalls its input.
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        write_base(CFG_BASE_DEC);
        hold_request = 1'b1;
        repeat (40) begin
            send_char(CH_0 + 8'($urandom_range(9)), 1'b1);
            send_char(8'h3B, 1'b0);
        end
        wait_quiet();
    endtask

    // Random traffic in three idling modes, each over several base settings.
    task automatic test_random_traffic();
        int target;
        for (int blk = 0; blk < 9; blk++) begin
            case (blk / 3)
                0:       begin tx_idle_pct = 11; rx_idle_pct = 67; end
                1:       begin tx_idle_pct = 67; rx_idle_pct = 11; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            case (blk)
                0, 4, 8: write_base(CFG_BASE_AUTO);
                1, 6:    write_base(CFG_BASE_HEX);
                2:       write_base(CFG_BASE_DEC);
                3:       write_base(CFG_BASE_OCT);
                5:       write_base(BASE_UNSUPPORTED_MAX);
                default: write_base(6'($urandom_range(36)));
            endcase
            target = random_chars + RANDOM_ITEMS / 9;
            while (random_chars < target) send_random_unit();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 11;
        rx_idle_pct = 67;
        test_auto_prefixes();
        test_fixed_bases();
        test_special_cases();
        test_value_wrap();
        test_backpressure();
        test_random_traffic();
        wait_quiet();
        $display("Ran %0d character beats and checked %0d results in %0d cycles,",
                 beats_in, results_seen, cycle_count);
        $display("over auto, octal, decimal, hex and unsupported bases with stalls both ways.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
